FILE: hw/rtl/pdm_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the PID differential-drive mixer modules.
package pdm_pkg;

  localparam int ERR_W      = 16;
  localparam int GAIN_W     = 8;
  localparam int SPEED_W    = 7;
  localparam int PWM_W      = 8;
  localparam int PCT_W      = 7;
  localparam int INTEG_W    = 32;
  localparam int BASE_W     = 9;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;

  // Shared multiplier operand widths (signed).
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 19;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Base speed = percent * 255 / 100, done as a reciprocal multiply.
  localparam int              BASE_SH  = 22;
  localparam logic [15:0]     BASE_MUL = 16'd41944;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_P     = 2'd0,
    REG_GAIN_I     = 2'd1,
    REG_GAIN_D     = 2'd2,
    REG_BASE_SPEED = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    MOP_NONE,
    MOP_INT,
    MOP_DIV,
    MOP_P,
    MOP_I,
    MOP_D,
    MOP_BASE,
    MOP_PCT_L,
    MOP_PCT_R
  } mul_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INT,
    ST_DIV,
    ST_P,
    ST_I,
    ST_D,
    ST_BASE,
    ST_CTL,
    ST_MIX,
    ST_PCT_L,
    ST_PCT_R,
    ST_SAVE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [SPEED_W-1:0] base_speed_percent;
  } pdm_cfg_t;

  typedef struct packed {
    logic    load;
    mul_op_t mul_op;
    logic    ctl_en;
    logic    mix_en;
    logic    out_load;
  } pdm_cmd_t;

endpackage

FILE: hw/rtl/pdm_regs.sv
`timescale 1ns / 1ps
// Configuration register file: gains and base speed.
module pdm_regs import pdm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output pdm_cfg_t              cfg
);

  pdm_cfg_t cfg_r;
  pdm_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_GAIN_P:     cfg_nxt.gain_p = cfg_wdata;
        REG_GAIN_I:     cfg_nxt.gain_i = cfg_wdata;
        REG_GAIN_D:     cfg_nxt.gain_d = cfg_wdata;
        REG_BASE_SPEED: cfg_nxt.base_speed_percent = cfg_wdata[SPEED_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/pdm_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: steps one sample through the shared multiplier and owns the output valid.
module pdm_ctrl import pdm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic     out_tready,
  output logic     out_tvalid,
  output pdm_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_INT;
      ST_INT:   state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_P;
      ST_P:     state_nxt = ST_I;
      ST_I:     state_nxt = ST_D;
      ST_D:     state_nxt = ST_BASE;
      ST_BASE:  state_nxt = ST_CTL;
      ST_CTL:   state_nxt = ST_MIX;
      ST_MIX:   state_nxt = ST_PCT_L;
      ST_PCT_L: state_nxt = ST_PCT_R;
      ST_PCT_R: state_nxt = ST_SAVE;
      ST_SAVE:  state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.out_load | (out_valid_r & ~out_tready);
  end

  // Commands.
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_INT:   cmd.mul_op = MOP_INT;
      ST_DIV:   cmd.mul_op = MOP_DIV;
      ST_P:     cmd.mul_op = MOP_P;
      ST_I:     cmd.mul_op = MOP_I;
      ST_D:     cmd.mul_op = MOP_D;
      ST_BASE:  cmd.mul_op = MOP_BASE;
      ST_CTL:   cmd.ctl_en = 1'b1;
      ST_MIX:   cmd.mix_en = 1'b1;
      ST_PCT_L: cmd.mul_op = MOP_PCT_L;
      ST_PCT_R: cmd.mul_op = MOP_PCT_R;
      ST_SAVE:  cmd.mul_op = MOP_NONE;
      ST_DONE:  cmd.out_load = !out_valid_r || out_tready;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // A waiting result beat is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result overwritten while stalled");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_INT))
    else $error("accepted beat did not start the sequence");

  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.out_load))
    else $error("output valid rose without a result load");

endmodule

FILE: hw/rtl/pdm_dp.sv
`timescale 1ns / 1ps
// Datapath: PID state, shared multiplier, mixing, clamp and percent conversion.
module pdm_dp import pdm_pkg::*; #(
  parameter int SAMPLE_PERIOD = 10,
  parameter int PWM_MAX       = 255
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pdm_cmd_t                cmd,
  input  pdm_cfg_t                cfg,
  input  logic signed [ERR_W-1:0] in_angle_error,
  output logic [ERR_W-1:0]        control_value,
  output logic [PWM_W-1:0]        left_duty,
  output logic [PWM_W-1:0]        right_duty,
  output logic [PCT_W-1:0]        left_percent,
  output logic [PCT_W-1:0]        right_percent
);

  // Exact division by constants: q = (n * ceil(2^(N+l)/D)) >> (N+l), 2^l >= D.
  localparam int DIV_SH = ERR_W + $clog2(SAMPLE_PERIOD);
  localparam longint unsigned DIV_MUL =
    ((64'd1 << DIV_SH) + SAMPLE_PERIOD - 1) / SAMPLE_PERIOD;
  localparam int PCT_SH = 15 + $clog2(PWM_MAX);
  localparam longint unsigned PCT_MUL =
    ((64'd1 << PCT_SH) + PWM_MAX - 1) / PWM_MAX;
  localparam logic [PWM_W-1:0] PWM_TOP = PWM_W'(PWM_MAX);

  function automatic logic [14:0] times100(input logic [PWM_W-1:0] v);
    times100 = (15'(v) << 6) + (15'(v) << 5) + (15'(v) << 2);
  endfunction

  function automatic logic [PWM_W-1:0] clamp_duty(input logic [ERR_W-1:0] v);
    if (v[ERR_W-1]) clamp_duty = '0;
    else if (v > ERR_W'(PWM_TOP)) clamp_duty = PWM_TOP;
    else clamp_duty = v[PWM_W-1:0];
  endfunction

  // Control state.
  logic signed [ERR_W-1:0] prev_r, prev_nxt;
  logic [INTEG_W-1:0]      integral_r, integral_nxt;
  mul_op_t                 op_r;

  // Working payload.
  logic signed [ERR_W-1:0]     err_r, err_nxt;
  logic [ERR_W-1:0]            dmag_r, dmag_nxt;
  logic                        dneg_r, dneg_nxt;
  logic signed [MUL_P_W-1:0]   mul_r;
  logic [ERR_W-1:0]            p_r, p_nxt, i_r, i_nxt, d_r, d_nxt, q_r, q_nxt;
  logic [ERR_W-1:0]            ctl_r, ctl_nxt;
  logic [BASE_W-1:0]           base_r, base_nxt;
  logic [PWM_W-1:0]            pwm_l_r, pwm_l_nxt, pwm_r_r, pwm_r_nxt;
  logic [PCT_W-1:0]            pct_l_r, pct_l_nxt, pct_r_r, pct_r_nxt;
  logic [ERR_W-1:0]            out_ctl_r, out_ctl_nxt;
  logic [PWM_W-1:0]            out_lpwm_r, out_lpwm_nxt, out_rpwm_r, out_rpwm_nxt;
  logic [PCT_W-1:0]            out_lpct_r, out_lpct_nxt, out_rpct_r, out_rpct_nxt;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic [MUL_P_W-1:0]        mul_u;
  logic [ERR_W-1:0]          div_q;
  logic signed [ERR_W:0]     diff;
  logic [ERR_W:0]            diff_mag;
  logic [14:0]               base_num;
  logic [ERR_W-1:0]          left_sum, right_sum;

  assign diff     = {in_angle_error[ERR_W-1], in_angle_error} - {prev_r[ERR_W-1], prev_r};
  assign diff_mag = diff[ERR_W] ? (ERR_W+1)'(-diff) : diff;
  assign base_num = {cfg.base_speed_percent, 8'b0} - 15'(cfg.base_speed_percent);
  assign mul_u    = mul_r;
  assign div_q    = ERR_W'(mul_u >> DIV_SH);
  assign left_sum  = ERR_W'(base_r) + ctl_r;
  assign right_sum = ERR_W'(base_r) - ctl_r;

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MOP_INT: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = MUL_B_W'(SAMPLE_PERIOD);
      end
      MOP_DIV: begin
        mul_a = MUL_A_W'(dmag_r);
        mul_b = MUL_B_W'(DIV_MUL);
      end
      MOP_P: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = MUL_B_W'(cfg.gain_p);
      end
      MOP_I: begin
        mul_a = MUL_A_W'($signed(integral_r[ERR_W-1:0]));
        mul_b = MUL_B_W'(cfg.gain_i);
      end
      MOP_D: begin
        mul_a = MUL_A_W'(q_r);
        mul_b = MUL_B_W'(cfg.gain_d);
      end
      MOP_BASE: begin
        mul_a = MUL_A_W'(base_num);
        mul_b = MUL_B_W'(BASE_MUL);
      end
      MOP_PCT_L: begin
        mul_a = MUL_A_W'(times100(pwm_l_r));
        mul_b = MUL_B_W'(PCT_MUL);
      end
      MOP_PCT_R: begin
        mul_a = MUL_A_W'(times100(pwm_r_r));
        mul_b = MUL_B_W'(PCT_MUL);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    prev_nxt     = prev_r;
    integral_nxt = integral_r;
    err_nxt      = err_r;
    dmag_nxt     = dmag_r;
    dneg_nxt     = dneg_r;
    p_nxt        = p_r;
    i_nxt        = i_r;
    d_nxt        = d_r;
    q_nxt        = q_r;
    ctl_nxt      = ctl_r;
    base_nxt     = base_r;
    pwm_l_nxt    = pwm_l_r;
    pwm_r_nxt    = pwm_r_r;
    pct_l_nxt    = pct_l_r;
    pct_r_nxt    = pct_r_r;
    out_ctl_nxt  = out_ctl_r;
    out_lpwm_nxt = out_lpwm_r;
    out_rpwm_nxt = out_rpwm_r;
    out_lpct_nxt = out_lpct_r;
    out_rpct_nxt = out_rpct_r;

    if (cmd.load) begin
      err_nxt  = in_angle_error;
      prev_nxt = in_angle_error;
      dmag_nxt = diff_mag[ERR_W-1:0];
      dneg_nxt = diff[ERR_W];
    end

    // Retire the product issued in the cycle before.
    case (op_r)
      MOP_INT:   integral_nxt = integral_r + mul_u[INTEG_W-1:0];
      MOP_DIV:   q_nxt = dneg_r ? (ERR_W'(0) - div_q) : div_q;
      MOP_P:     p_nxt = mul_u[ERR_W-1:0];
      MOP_I:     i_nxt = mul_u[ERR_W-1:0];
      MOP_D:     d_nxt = mul_u[ERR_W-1:0];
      MOP_BASE:  base_nxt = BASE_W'(mul_u >> BASE_SH);
      MOP_PCT_L: pct_l_nxt = PCT_W'(mul_u >> PCT_SH);
      MOP_PCT_R: pct_r_nxt = PCT_W'(mul_u >> PCT_SH);
      default:   q_nxt = q_r;
    endcase

    if (cmd.ctl_en) begin
      ctl_nxt = p_r + i_r + d_r;
    end

    if (cmd.mix_en) begin
      pwm_l_nxt = clamp_duty(left_sum);
      pwm_r_nxt = clamp_duty(right_sum);
    end

    if (cmd.out_load) begin
      out_ctl_nxt  = ctl_r;
      out_lpwm_nxt = pwm_l_r;
      out_rpwm_nxt = pwm_r_r;
      out_lpct_nxt = pct_l_r;
      out_rpct_nxt = pct_r_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      integral_r <= '0;
      op_r       <= MOP_NONE;
    end else begin
      prev_r     <= prev_nxt;
      integral_r <= integral_nxt;
      op_r       <= cmd.mul_op;
    end
  end

  always_ff @(posedge clk) begin
    err_r      <= err_nxt;
    dmag_r     <= dmag_nxt;
    dneg_r     <= dneg_nxt;
    mul_r      <= mul_p;
    p_r        <= p_nxt;
    i_r        <= i_nxt;
    d_r        <= d_nxt;
    q_r        <= q_nxt;
    ctl_r      <= ctl_nxt;
    base_r     <= base_nxt;
    pwm_l_r    <= pwm_l_nxt;
    pwm_r_r    <= pwm_r_nxt;
    pct_l_r    <= pct_l_nxt;
    pct_r_r    <= pct_r_nxt;
    out_ctl_r  <= out_ctl_nxt;
    out_lpwm_r <= out_lpwm_nxt;
    out_rpwm_r <= out_rpwm_nxt;
    out_lpct_r <= out_lpct_nxt;
    out_rpct_r <= out_rpct_nxt;
  end

  assign control_value = out_ctl_r;
  assign left_duty     = out_lpwm_r;
  assign right_duty    = out_rpwm_r;
  assign left_percent  = out_lpct_r;
  assign right_percent = out_rpct_r;

  a_integ_only_on_int: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(integral_r)) |-> $past(op_r == MOP_INT))
    else $error("integral changed outside its update step");

  a_prev_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(prev_r)) |-> $past(cmd.load))
    else $error("previous error changed without an accepted beat");

endmodule

FILE: hw/rtl/pid_differential_drive_mixer.sv
`timescale 1ns / 1ps
// PID controller with differential-drive mixing: one angle-error beat in, one result beat out.
// Each accepted angle-error beat updates the running integral and the previous error and
// yields one result beat: the 16-bit wrapped P+I+D control value, the left and right duty
// (base speed plus and minus control, clamped to 0..PWM_MAX) and both duties in percent.
// The result beat turns valid once its sample has been through every step, and a new
// sample is taken only after that. Eight products pass through a single shared multiplier:
// the integral step, derivative division, P, I, D and base speed, one after another; then
// come the control sum, mixing and clamping, the left and right percentages, a step that
// retires the last product, the output register load and the idle state that accepts the
// next sample. The result sits in an output register, so the next sample is taken while a
// result beat still waits; the sequencer only holds when a second result is finished
// before the first one has been taken.
module pid_differential_drive_mixer import pdm_pkg::*; #(
  parameter int SAMPLE_PERIOD = 10,
  parameter int PWM_MAX       = 255
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Config write port.
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] angle_error
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata   // [15:0] control_value, [23:16] left duty,
                                            // [31:24] right duty, [38:32] left_percent,
                                            // [45:39] right_percent, [47:46] zero
);

  pdm_cfg_t         cfg;
  pdm_cmd_t         cmd;
  logic [ERR_W-1:0] control_value;
  logic [PWM_W-1:0] left_duty;
  logic [PWM_W-1:0] right_duty;
  logic [PCT_W-1:0] left_percent;
  logic [PCT_W-1:0] right_percent;

  pdm_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pdm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  pdm_dp #(
    .SAMPLE_PERIOD (SAMPLE_PERIOD),
    .PWM_MAX       (PWM_MAX)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg            (cfg),
    .in_angle_error ($signed(in_tdata)),
    .control_value  (control_value),
    .left_duty      (left_duty),
    .right_duty     (right_duty),
    .left_percent   (left_percent),
    .right_percent  (right_percent)
  );

  assign out_tdata = {2'b00, right_percent, left_percent, right_duty, left_duty, control_value};

endmodule

FILE: test/pid_differential_drive_mixer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the PID differential-drive mixer: directed table, then random.
module pid_differential_drive_mixer_tb import pdm_pkg::*; ;

  localparam int SAMPLE_PERIOD = 10;
  localparam int PWM_MAX       = 255;
  localparam int BASE_NUM      = 255;
  localparam int PCT_FULL      = 100;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int RAND_SEGMENTS = 25;
  localparam int SEG_ITEMS     = 50;
  localparam int HOLD_SEGMENT  = 20;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Same bit order as out_tdata: control_value in the lowest bits.
  typedef struct packed {
    logic [PCT_W-1:0] right_pct;
    logic [PCT_W-1:0] left_pct;
    logic [PWM_W-1:0] right_duty;
    logic [PWM_W-1:0] left_duty;
    logic [15:0]      control_value;
  } drive_result_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_PREDICT,
    ROW_KNOWN
  } row_kind_t;

  typedef struct {
    row_kind_t     kind;
    logic [7:0]    gp;
    logic [7:0]    gi;
    logic [7:0]    gd;
    logic [7:0]    bs;
    logic [15:0]   err;
    drive_result_t res;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;   // [15:0] angle_error
  logic                  out_tvalid;
  logic                  out_tready;
  logic [47:0]           out_tdata;  // [15:0] control_value, [23:16] left duty,
                                     // [31:24] right duty, [38:32] left_percent,
                                     // [45:39] right_percent, [47:46] zero

  // Predictor state
  pdm_cfg_t           model_cfg;
  logic [31:0]        integ_acc;
  logic signed [15:0] last_err;
  drive_result_t      expected_q[$];
  stim_row_t          dir_rows[$];

  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_off_go;
  int          mismatch_count = 0;
  int          results_checked = 0;
  int          samples_sent;
  int          directed_sent;
  int          cfg_loads;
  int unsigned cycle_count = 0;

  pid_differential_drive_mixer #(
    .SAMPLE_PERIOD (SAMPLE_PERIOD),
    .PWM_MAX       (PWM_MAX)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timed out after %0d cycles, %0d results outstanding", cycle_count,
             expected_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [PWM_W-1:0] duty_clamp(input logic signed [15:0] v);
    if (v < 0) begin
      return '0;
    end
    if (v > PWM_MAX) begin
      return PWM_W'(PWM_MAX);
    end
    return v[PWM_W-1:0];
  endfunction

  // Advance the controller state by one error sample and return the drive outputs.
  function automatic drive_result_t pid_mix_step(input logic signed [15:0] err);
    int                 e;
    int                 q;
    int                 p_t;
    int                 i_t;
    int                 d_t;
    int                 base;
    logic signed [15:0] integ_lo;
    logic signed [15:0] ctl;
    drive_result_t      r;
    e = err;
    p_t = int'(model_cfg.gain_p) * e;
    // the integral keeps running even with zero integral gain
    integ_acc = integ_acc + 32'(e * SAMPLE_PERIOD);
    integ_lo = integ_acc[15:0];
    i_t = int'(model_cfg.gain_i) * int'(integ_lo);
    q = (e - int'(last_err)) / SAMPLE_PERIOD;
    d_t = int'(model_cfg.gain_d) * q;
    ctl = 16'(p_t + i_t + d_t);
    last_err = err;
    base = int'(model_cfg.base_speed_percent) * BASE_NUM / PCT_FULL;
    r.control_value = ctl;
    // wrap to 16 signed bits before clamping
    r.left_duty  = duty_clamp(16'(base + int'(ctl)));
    r.right_duty = duty_clamp(16'(base - int'(ctl)));
    r.left_pct   = PCT_W'(int'(r.left_duty) * PCT_FULL / PWM_MAX);
    r.right_pct  = PCT_W'(int'(r.right_duty) * PCT_FULL / PWM_MAX);
    return r;
  endfunction

  function automatic void add_cfg_row(input logic [7:0] gp, input logic [7:0] gi,
                                      input logic [7:0] gd, input logic [7:0] bs);
    stim_row_t row;
    row = '{kind: ROW_CFG, gp: gp, gi: gi, gd: gd, bs: bs, err: '0, res: '0};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_row(input logic [15:0] err);
    stim_row_t row;
    row = '{kind: ROW_PREDICT, gp: '0, gi: '0, gd: '0, bs: '0, err: err, res: '0};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_known_row(input logic [15:0] err, input logic [15:0] ctl,
                                        input logic [7:0] lduty, input logic [7:0] rduty,
                                        input logic [6:0] lpct, input logic [6:0] rpct);
    stim_row_t row;
    row = '{kind: ROW_KNOWN, gp: '0, gi: '0, gd: '0, bs: '0, err: err,
            res: '{right_pct: rpct, left_pct: lpct, right_duty: rduty, left_duty: lduty,
                   control_value: ctl}};
    dir_rows.push_back(row);
  endfunction

  function automatic logic [15:0] random_error();
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4: return 16'($urandom_range(1000, 0) - 500);
      5, 6, 7:       return 16'($urandom_range(10000, 0) - 5000);
      8: begin
        case ($urandom_range(3, 0))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'hFFFF;
          default: return 16'h0000;
        endcase
      end
      default:       return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] random_gain();
    case ($urandom_range(5, 0))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3:    return 8'($urandom_range(16, 0));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] random_base();
    if ($urandom_range(3, 0) == 0) begin
      return 8'($urandom);
    end
    return 8'($urandom_range(100, 0));
  endfunction

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatch_count++;
    $display("mismatch at result %0d: %s got 'h%0h, expected 'h%0h", results_checked,
             field, got, want);
  endtask

  // Offer one sample, hold it until accepted, then queue its expected outputs.
  task automatic send_sample(input logic [15:0] err, input bit known,
                             input drive_result_t typed);
    drive_result_t pred;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= err;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    pred = pid_mix_step(err);
    expected_q.push_back(known ? typed : pred);
    samples_sent++;
  endtask

  // Stop offering and wait until every queued result has come back, plus some slack.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input logic [7:0] gp, input logic [7:0] gi,
                             input logic [7:0] gd, input logic [7:0] bs);
    logic [7:0] vals[4];
    reg_idx_t   idx;
    vals = '{gp, gi, gd, bs};
    for (int k = 0; k < 4; k++) begin
      idx = reg_idx_t'(k);
      cfg_we    <= 1'b1;
      cfg_addr  <= idx;
      cfg_wdata <= vals[k];
      @(posedge clk);
      case (idx)
        REG_GAIN_P:     model_cfg.gain_p = vals[k];
        REG_GAIN_I:     model_cfg.gain_i = vals[k];
        REG_GAIN_D:     model_cfg.gain_d = vals[k];
        REG_BASE_SPEED: model_cfg.base_speed_percent = vals[k][SPEED_W-1:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
    cfg_loads++;
  endtask

  // Result side: random backpressure, plus one long hold-off on request.
  initial begin : result_sink
    bit hold_done;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_go && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    drive_result_t got;
    drive_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = drive_result_t'(out_tdata[45:0]);
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", got.control_value, '0);
      end else begin
        want = expected_q.pop_front();
        if (got.control_value !== want.control_value)
          report_mismatch("control_value", got.control_value, want.control_value);
        if (got.left_duty !== want.left_duty)
          report_mismatch("left_duty", 16'(got.left_duty), 16'(want.left_duty));
        if (got.right_duty !== want.right_duty)
          report_mismatch("right_duty", 16'(got.right_duty), 16'(want.right_duty));
        if (got.left_pct !== want.left_pct)
          report_mismatch("left_percent", 16'(got.left_pct), 16'(want.left_pct));
        if (got.right_pct !== want.right_pct)
          report_mismatch("right_percent", 16'(got.right_pct), 16'(want.right_pct));
      end
      results_checked++;
    end
  end

  initial begin : stimulus
    drive_result_t none;
    none = '0;
    samples_sent    = 0;
    directed_sent   = 0;
    cfg_loads       = 0;
    hold_off_go     = 1'b0;
    send_idle_pct   = 17;
    recv_idle_pct   = 62;
    model_cfg       = '0;
    integ_acc       = '0;
    last_err        = '0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_GAIN_P;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;

    // Out of reset: all gains and base speed are zero, the integral still runs.
    add_known_row(16'h0000, 16'h0000, 8'd0, 8'd0, 7'd0, 7'd0);
    add_known_row(16'h7FFF, 16'h0000, 8'd0, 8'd0, 7'd0, 7'd0);
    add_known_row(16'h8000, 16'h0000, 8'd0, 8'd0, 7'd0, 7'd0);
    // Pure P at full base speed
    add_cfg_row(8'd1, 8'd0, 8'd0, 8'd100);
    add_known_row(16'h0000, 16'h0000, 8'd255, 8'd255, 7'd100, 7'd100);
    add_known_row(16'd10, 16'd10, 8'd255, 8'd245, 7'd100, 7'd96);
    add_known_row(-16'sd300, -16'sd300, 8'd0, 8'd255, 7'd0, 7'd100);
    // extreme control wraps the mix sum in sign on both sides
    add_known_row(16'h7FFF, 16'h7FFF, 8'd0, 8'd0, 7'd0, 7'd0);
    add_known_row(16'h8000, 16'h8000, 8'd0, 8'd0, 7'd0, 7'd0);
    // base above one hundred percent; top bit of the write data is dropped
    add_cfg_row(8'd0, 8'd0, 8'd0, 8'hE5);
    add_known_row(16'd1234, 16'h0000, 8'd255, 8'd255, 7'd100, 7'd100);
    // all gains and base speed at maximum
    add_cfg_row(8'hFF, 8'hFF, 8'hFF, 8'd127);
    add_row(16'h7FFF);
    add_row(16'h8000);
    add_row(16'h0000);
    add_row(16'h0001);
    add_row(16'hFFFF);
    add_row(16'h5555);
    add_row(16'hAAAA);
    // derivative truncation toward zero on both signs
    add_cfg_row(8'd3, 8'd0, 8'd7, 8'd50);
    add_row(16'd19);
    add_row(16'd0);
    add_row(-16'sd19);
    add_row(-16'sd5);
    add_row(16'd6);
    add_cfg_row(8'd2, 8'd1, 8'd0, 8'd0);
    add_row(16'd100);
    add_row(16'd100);
    add_row(-16'sd250);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      case (dir_rows[k].kind)
        ROW_CFG: begin
          drain_results();
          load_config(dir_rows[k].gp, dir_rows[k].gi, dir_rows[k].gd, dir_rows[k].bs);
        end
        ROW_KNOWN:   send_sample(dir_rows[k].err, 1'b1, dir_rows[k].res);
        default:     send_sample(dir_rows[k].err, 1'b0, none);
      endcase
    end
    directed_sent = samples_sent;

    for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
      if (seg < 9) begin
        send_idle_pct = 17;
        recv_idle_pct = 62;
      end else if (seg < 17) begin
        send_idle_pct = 62;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain_results();
      load_config(random_gain(), random_gain(), random_gain(), random_base());
      // stall the result side while samples keep coming, so the input backs up
      if (seg == HOLD_SEGMENT) begin
        hold_off_go = 1'b1;
      end
      for (int k = 0; k < SEG_ITEMS; k++) begin
        send_sample(random_error(), 1'b0, none);
      end
    end

    drain_results();
    $display("run covered %0d angle-error samples (%0d from the directed table) over %0d",
             samples_sent, directed_sent, cfg_loads);
    $display("gain settings; %0d result beats checked, %0d mismatches, %0d cycles",
             results_checked, mismatch_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/pdm_pkg.sv
hw/rtl/pdm_regs.sv
hw/rtl/pdm_ctrl.sv
hw/rtl/pdm_dp.sv
hw/rtl/pid_differential_drive_mixer.sv
test/pid_differential_drive_mixer_tb.sv
